/* src/rrp_pkg.sv */
// Package for the request parser: widths, register indexes, event and phase codes, result type.
package rrp_pkg;

  // Parameter defaults
  localparam int COUNT_BITS_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 32;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int EVENT_W  = 3;
  localparam int INDEX_W  = 16;
  localparam int MAXEL_W  = 16;
  localparam int MAXLEN_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PHASE_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELEMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 2'd1;

  // Configuration reset values
  localparam logic [MAXEL_W-1:0]  MAX_ELEMENTS_RST = 16'd1024;
  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST   = 32'd536870912;

  // Event codes
  localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DATA = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ELEM = 3'd2;
  localparam logic [EVENT_W-1:0] EV_REQ  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_ERR  = 3'd4;

  // Parser phases
  localparam logic [PHASE_W-1:0] PH_STAR    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CNT     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CNT_LF  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DOLLAR  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LEN     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_LEN_LF  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_BODY    = 3'd6;
  localparam logic [PHASE_W-1:0] PH_BODY_LF = 3'd7;

  // Characters
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9      = 8'h39;

  // One result item
  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] element_index;
  } res_t;

endpackage

/* src/rrp_intf.sv */
// Channel interfaces of the request parser: input bytes, result items, configuration writes.
interface rrp_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrp_pkg::BYTE_W-1:0]  in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rrp_out_if;
  logic                         valid;
  logic                         ready;
  logic [rrp_pkg::EVENT_W-1:0]  event_res;
  logic [rrp_pkg::BYTE_W-1:0]   data_byte;
  logic [rrp_pkg::INDEX_W-1:0]  element_index;
  modport source (output valid, output event_res, output data_byte, output element_index,
                  input ready);
  modport sink (input valid, input event_res, input data_byte, input element_index,
                output ready);
endinterface

interface rrp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrp_pkg::CFG_IDX_W-1:0]  index;
  logic [rrp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/rrp_step.sv */
// Next-state and result logic of the parser for one request byte.
module rrp_step #(
  parameter int COUNT_BITS  = rrp_pkg::COUNT_BITS_DEF,
  parameter int LENGTH_BITS = rrp_pkg::LENGTH_BITS_DEF
) (
  input  logic [rrp_pkg::BYTE_W-1:0]   byte_i,
  input  logic [rrp_pkg::MAXEL_W-1:0]  max_elements_i,
  input  logic [rrp_pkg::MAXLEN_W-1:0] max_length_i,
  input  logic [rrp_pkg::PHASE_W-1:0]  phase_i,
  input  logic [COUNT_BITS-1:0]        elements_left_i,
  input  logic [LENGTH_BITS-1:0]       bytes_left_i,
  input  logic [rrp_pkg::INDEX_W-1:0]  cur_elem_i,
  input  logic                         just_fin_i,
  input  logic                         resync_i,
  output logic [rrp_pkg::PHASE_W-1:0]  phase_o,
  output logic [COUNT_BITS-1:0]        elements_left_o,
  output logic [LENGTH_BITS-1:0]       bytes_left_o,
  output logic [rrp_pkg::INDEX_W-1:0]  cur_elem_o,
  output logic                         just_fin_o,
  output logic                         resync_o,
  output rrp_pkg::res_t                res_o
);

  localparam int CW  = COUNT_BITS + 4;
  localparam int LW  = LENGTH_BITS + 4;
  localparam int CMW = (CW > rrp_pkg::MAXEL_W) ? CW : rrp_pkg::MAXEL_W;
  localparam int LMW = (LW > rrp_pkg::MAXLEN_W) ? LW : rrp_pkg::MAXLEN_W;

  logic [rrp_pkg::BYTE_W-1:0] dig_full;
  logic [3:0]                 digit;
  logic                       is_digit;
  logic [CW-1:0]              cnt_ext;
  logic [CW-1:0]              cnt_v;
  logic                       cnt_over;
  logic [LW-1:0]              len_ext;
  logic [LW-1:0]              len_v;
  logic                       len_over;
  logic                       do_err;
  logic                       do_fin;

  // Decimal digit value
  assign dig_full = byte_i - rrp_pkg::CH_0;
  assign digit    = dig_full[3:0];
  assign is_digit = (byte_i >= rrp_pkg::CH_0) && (byte_i <= rrp_pkg::CH_9);

  // Accumulate count digit: times ten by shift-add, then limit check
  assign cnt_ext  = CW'(elements_left_i);
  assign cnt_v    = (cnt_ext << 3) + (cnt_ext << 1) + CW'(digit);
  assign cnt_over = (cnt_v[CW-1:COUNT_BITS] != '0) || (CMW'(cnt_v) > CMW'(max_elements_i));

  // Accumulate length digit
  assign len_ext  = LW'(bytes_left_i);
  assign len_v    = (len_ext << 3) + (len_ext << 1) + LW'(digit);
  assign len_over = (len_v[LW-1:LENGTH_BITS] != '0) || (LMW'(len_v) > LMW'(max_length_i));

  // Parse one byte
  always_comb begin
    phase_o         = phase_i;
    elements_left_o = elements_left_i;
    bytes_left_o    = bytes_left_i;
    cur_elem_o      = cur_elem_i;
    just_fin_o      = 1'b0;
    resync_o        = resync_i;
    res_o.event_res     = rrp_pkg::EV_NONE;
    res_o.data_byte     = '0;
    res_o.element_index = cur_elem_i;
    do_err = 1'b0;
    do_fin = 1'b0;

    if (!(just_fin_i && (byte_i == rrp_pkg::CH_NUL))) begin
      case (phase_i)
        rrp_pkg::PH_STAR: begin
          if (byte_i == rrp_pkg::CH_STAR) begin
            resync_o        = 1'b0;
            elements_left_o = '0;
            phase_o         = rrp_pkg::PH_CNT;
          end else if (!resync_i) begin
            do_err = 1'b1;
          end
        end
        rrp_pkg::PH_CNT: begin
          if (is_digit) begin
            if (cnt_over) begin
              do_err = 1'b1;
            end else begin
              elements_left_o = cnt_v[COUNT_BITS-1:0];
            end
          end else if (byte_i == rrp_pkg::CH_CR) begin
            phase_o = rrp_pkg::PH_CNT_LF;
          end else begin
            do_err = 1'b1;
          end
        end
        rrp_pkg::PH_CNT_LF: begin
          if (byte_i != rrp_pkg::CH_LF) begin
            do_err = 1'b1;
          end else if (elements_left_i == '0) begin
            do_fin = 1'b1;
          end else begin
            phase_o = rrp_pkg::PH_DOLLAR;
          end
        end
        rrp_pkg::PH_DOLLAR: begin
          if (byte_i != rrp_pkg::CH_DOLLAR) begin
            do_err = 1'b1;
          end else begin
            bytes_left_o = '0;
            phase_o      = rrp_pkg::PH_LEN;
          end
        end
        rrp_pkg::PH_LEN: begin
          if (is_digit) begin
            if (len_over) begin
              do_err = 1'b1;
            end else begin
              bytes_left_o = len_v[LENGTH_BITS-1:0];
            end
          end else if (byte_i == rrp_pkg::CH_CR) begin
            phase_o = rrp_pkg::PH_LEN_LF;
          end else begin
            do_err = 1'b1;
          end
        end
        rrp_pkg::PH_LEN_LF: begin
          if (byte_i != rrp_pkg::CH_LF) begin
            do_err = 1'b1;
          end else begin
            elements_left_o = elements_left_i - 1'b1;
            phase_o         = rrp_pkg::PH_BODY;
          end
        end
        rrp_pkg::PH_BODY: begin
          if (bytes_left_i != '0) begin
            bytes_left_o    = bytes_left_i - 1'b1;
            res_o.data_byte = byte_i;
            res_o.event_res = rrp_pkg::EV_DATA;
          end else if (byte_i == rrp_pkg::CH_CR) begin
            phase_o = rrp_pkg::PH_BODY_LF;
          end else begin
            do_err = 1'b1;
          end
        end
        rrp_pkg::PH_BODY_LF: begin
          if (byte_i != rrp_pkg::CH_LF) begin
            do_err = 1'b1;
          end else if (elements_left_i == '0) begin
            do_fin = 1'b1;
          end else begin
            cur_elem_o      = cur_elem_i + 1'b1;
            phase_o         = rrp_pkg::PH_DOLLAR;
            res_o.event_res = rrp_pkg::EV_ELEM;
          end
        end
        default: begin
          do_err = 1'b1;
        end
      endcase

      // Drop the request on error or completion
      if (do_err || do_fin) begin
        phase_o         = rrp_pkg::PH_STAR;
        elements_left_o = '0;
        bytes_left_o    = '0;
        cur_elem_o      = '0;
        res_o.data_byte = '0;
      end
      if (do_err) begin
        resync_o        = 1'b1;
        res_o.event_res = rrp_pkg::EV_ERR;
      end
      if (do_fin) begin
        just_fin_o      = 1'b1;
        res_o.event_res = rrp_pkg::EV_REQ;
      end
    end
  end

endmodule

/* src/resp_request_parser.sv */
// Top level of the request parser: input register, parser state, result register, config.
//
// Usage: request bytes enter on in_i, one item per byte. Every byte gives exactly
// one result item on out_o: an event code (nothing, payload byte, element complete,
// request complete, error), the payload byte, and the index of the current element.
// Limits are written on cfg_i: index 0 sets max_elements, index 1 sets max_length;
// other indexes are ignored. cfg_i is always ready.
// A byte accepted on in_i is held in the input register; the parser update then
// writes its result into the result register, which drives out_o.
// Throughput: one byte per cycle while out_o is not stalled, set by the update of
// the parser state (phase, counts, element index) from the registered byte.
// Reset clears the parser to wait for a '*', clears both pipeline stages and
// loads the default limits (1024 elements, 536870912 bytes).
// When the receiver stalls, the result register holds its item and the input
// register takes one more byte; in_i.ready then drops until out_o moves again.
module resp_request_parser #(
  parameter int COUNT_BITS  = rrp_pkg::COUNT_BITS_DEF,
  parameter int LENGTH_BITS = rrp_pkg::LENGTH_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rrp_in_if.sink   in_i,
  rrp_out_if.source out_o,
  rrp_cfg_if.sink  cfg_i
);

  logic [rrp_pkg::MAXEL_W-1:0]  max_elements_q;
  logic [rrp_pkg::MAXLEN_W-1:0] max_length_q;

  logic                        in_valid_q, in_valid_d;
  logic [rrp_pkg::BYTE_W-1:0]  byte_q;
  logic                        out_valid_q, out_valid_d;
  rrp_pkg::res_t               res_q, res_d;
  logic                        advance;

  logic [rrp_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [COUNT_BITS-1:0]       elements_left_q, elements_left_d;
  logic [LENGTH_BITS-1:0]      bytes_left_q, bytes_left_d;
  logic [rrp_pkg::INDEX_W-1:0] cur_elem_q, cur_elem_d;
  logic                        just_fin_q, just_fin_d;
  logic                        resync_q, resync_d;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_elements_q <= rrp_pkg::MAX_ELEMENTS_RST;
      max_length_q   <= rrp_pkg::MAX_LENGTH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rrp_pkg::REG_MAX_ELEMENTS: max_elements_q <= cfg_i.data[rrp_pkg::MAXEL_W-1:0];
        rrp_pkg::REG_MAX_LENGTH:   max_length_q   <= cfg_i.data[rrp_pkg::MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the registered byte when the result register is free
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_valid_d  = (in_i.valid && in_i.ready) ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  rrp_step #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .byte_i          (byte_q),
    .max_elements_i  (max_elements_q),
    .max_length_i    (max_length_q),
    .phase_i         (phase_q),
    .elements_left_i (elements_left_q),
    .bytes_left_i    (bytes_left_q),
    .cur_elem_i      (cur_elem_q),
    .just_fin_i      (just_fin_q),
    .resync_i        (resync_q),
    .phase_o         (phase_d),
    .elements_left_o (elements_left_d),
    .bytes_left_o    (bytes_left_d),
    .cur_elem_o      (cur_elem_d),
    .just_fin_o      (just_fin_d),
    .resync_o        (resync_d),
    .res_o           (res_d)
  );

  // Pipeline valid bits and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      phase_q         <= rrp_pkg::PH_STAR;
      elements_left_q <= '0;
      bytes_left_q    <= '0;
      cur_elem_q      <= '0;
      just_fin_q      <= 1'b0;
      resync_q        <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q         <= phase_d;
        elements_left_q <= elements_left_d;
        bytes_left_q    <= bytes_left_d;
        cur_elem_q      <= cur_elem_d;
        just_fin_q      <= just_fin_d;
        resync_q        <= resync_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Drive the result channel
  assign out_o.valid         = out_valid_q;
  assign out_o.event_res     = res_q.event_res;
  assign out_o.data_byte     = res_q.data_byte;
  assign out_o.element_index = res_q.element_index;

endmodule

/* tb/sv/rrp_checker.sv */
// Checker for the request parser: predicts the result item of every accepted byte and compares.
`timescale 1ns / 100ps

module rrp_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rrp_in_if    in_i,
  rrp_out_if   out_i,
  rrp_cfg_if   cfg_i,
  output int   errors_o,
  output int   pending_o
);
  import rrp_pkg::*;

  localparam int SHOWN_MAX = 10;

  // Limits as last written
  logic [MAXEL_W-1:0]         lim_elements;
  logic [MAXLEN_W-1:0]        lim_length;

  // Predicted parser state
  logic [PHASE_W-1:0]         ph;
  logic [COUNT_BITS_DEF-1:0]  count_left;
  logic [LENGTH_BITS_DEF-1:0] len_left;
  logic [INDEX_W-1:0]         elem_idx;
  logic                       req_closed;
  logic                       hunting;

  res_t results_due[$];
  int   mismatches;

  // Drop the request and hunt for the next star
  function automatic logic [EVENT_W-1:0] take_error();
    ph         = PH_STAR;
    count_left = '0;
    len_left   = '0;
    elem_idx   = '0;
    req_closed = 1'b0;
    hunting    = 1'b1;
    return EV_ERR;
  endfunction

  function automatic logic [EVENT_W-1:0] close_request();
    ph         = PH_STAR;
    count_left = '0;
    len_left   = '0;
    elem_idx   = '0;
    req_closed = 1'b1;
    return EV_REQ;
  endfunction

  // Advance the predicted parser by one byte and return its result item.
  // The count limit never exceeds the 16-bit count range and the length
  // limit never exceeds the 32-bit length range, so no cap is needed.
  function automatic res_t parse_byte(input logic [BYTE_W-1:0] b);
    res_t        r;
    logic [63:0] acc;
    logic        is_dig;
    r.event_res     = EV_NONE;
    r.data_byte     = '0;
    r.element_index = elem_idx;
    is_dig = (b >= CH_0) && (b <= CH_9);
    acc    = '0;
    // A single NUL right after a request end is swallowed
    if (req_closed) begin
      req_closed = 1'b0;
      if (b == CH_NUL) return r;
    end
    case (ph)
      PH_STAR: begin
        if (b == CH_STAR) begin
          hunting    = 1'b0;
          count_left = '0;
          ph         = PH_CNT;
        end else if (!hunting) begin
          r.event_res = take_error();
        end
      end
      PH_CNT: begin
        if (is_dig) begin
          acc = 64'(count_left) * 64'd10 + 64'(b - CH_0);
          if (acc > 64'(lim_elements)) r.event_res = take_error();
          else count_left = acc[COUNT_BITS_DEF-1:0];
        end else if (b == CH_CR) begin
          ph = PH_CNT_LF;
        end else begin
          r.event_res = take_error();
        end
      end
      PH_CNT_LF: begin
        if (b != CH_LF) r.event_res = take_error();
        else if (count_left == '0) r.event_res = close_request();
        else ph = PH_DOLLAR;
      end
      PH_DOLLAR: begin
        if (b != CH_DOLLAR) begin
          r.event_res = take_error();
        end else begin
          len_left = '0;
          ph       = PH_LEN;
        end
      end
      PH_LEN: begin
        if (is_dig) begin
          acc = 64'(len_left) * 64'd10 + 64'(b - CH_0);
          if (acc > 64'(lim_length)) r.event_res = take_error();
          else len_left = acc[LENGTH_BITS_DEF-1:0];
        end else if (b == CH_CR) begin
          ph = PH_LEN_LF;
        end else begin
          r.event_res = take_error();
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          r.event_res = take_error();
        end else begin
          count_left = count_left - 1'b1;
          ph         = PH_BODY;
        end
      end
      PH_BODY: begin
        if (len_left != '0) begin
          len_left    = len_left - 1'b1;
          r.data_byte = b;
          r.event_res = EV_DATA;
        end else if (b == CH_CR) begin
          ph = PH_BODY_LF;
        end else begin
          r.event_res = take_error();
        end
      end
      PH_BODY_LF: begin
        if (b != CH_LF) begin
          r.event_res = take_error();
        end else if (count_left == '0) begin
          r.event_res = close_request();
        end else begin
          elem_idx    = elem_idx + 1'b1;
          ph          = PH_DOLLAR;
          r.event_res = EV_ELEM;
        end
      end
      default: r.event_res = take_error();
    endcase
    return r;
  endfunction

  task automatic note_failure(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= SHOWN_MAX)
      $display("%0t %s: expected event %0d data %02h index %0d, got event %0d data %02h index %0d",
               $time, what, want.event_res, want.data_byte, want.element_index,
               got.event_res, got.data_byte, got.element_index);
  endtask

  // Watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      lim_elements = MAX_ELEMENTS_RST;
      lim_length   = MAX_LENGTH_RST;
      ph           = PH_STAR;
      count_left   = '0;
      len_left     = '0;
      elem_idx     = '0;
      req_closed   = 1'b0;
      hunting      = 1'b0;
      mismatches   = 0;
      results_due.delete();
    end else begin
      // Compare the item leaving the block before predicting new ones
      if (out_i.valid && out_i.ready) begin
        got.event_res     = out_i.event_res;
        got.data_byte     = out_i.data_byte;
        got.element_index = out_i.element_index;
        if (results_due.size() == 0) begin
          note_failure("unexpected item", '0, got);
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (want !== got) note_failure("mismatch", want, got);
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_MAX_ELEMENTS) lim_elements = cfg_i.data[MAXEL_W-1:0];
        else if (cfg_i.index == REG_MAX_LENGTH) lim_length = cfg_i.data[MAXLEN_W-1:0];
      end
      if (in_i.valid && in_i.ready)
        results_due.insert(results_due.size(), parse_byte(in_i.in_byte));
    end
    errors_o  <= mismatches;
    pending_o <= results_due.size();
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the request parser testbench: clock, reset, byte stimulus, limit writes and verdict.
`timescale 1ns / 100ps

module testbench;
  import rrp_pkg::*;

  // Indexes that name no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int RANDOM_BYTES  = 1600;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 5000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   bytes_sent     = 0;
  int   chk_errors;
  int   chk_pending;
  logic [BYTE_W-1:0] req_q[$];

  rrp_in_if  in_ch ();
  rrp_out_if out_ch ();
  rrp_cfg_if cfg_ch ();

  resp_request_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  rrp_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .cfg_i     (cfg_ch),
    .errors_o  (chk_errors),
    .pending_o (chk_pending)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: stall at random per the current phase
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Hold off until every result has come back, then let the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (chk_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both limits, preceded by a write to an unused index
  task automatic write_limits(input logic [MAXEL_W-1:0] el, input logic [MAXLEN_W-1:0] len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
    cfg_ch.data  <= $urandom;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.index <= REG_MAX_ELEMENTS;
    cfg_ch.data  <= {16'($urandom), el};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.index <= REG_MAX_LENGTH;
    cfg_ch.data  <= len;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Append one byte to the request being built
  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    req_q.insert(req_q.size(), b);
  endtask

  // Append a decimal number; zero may come as an empty digit run
  task automatic add_number(input int unsigned n);
    string digits;
    digits = $sformatf("%0d", n);
    if (n == 0 && $urandom_range(3) == 0) return;
    if ($urandom_range(7) == 0) queue_byte(CH_0);
    for (int k = 0; k < digits.len(); k++) queue_byte(digits[k]);
  endtask

  // Mostly well-formed requests with random content, plus noise and broken requests
  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned half_way;
    int unsigned n_el;
    int unsigned len;
    int unsigned roll;
    int unsigned cut;
    logic        paused;
    stop_at  = bytes_sent + quota;
    half_way = bytes_sent + quota / 2;
    paused   = 1'b0;
    while (bytes_sent < stop_at) begin
      req_q.delete();
      n_el = ($urandom_range(15) == 0) ? $urandom_range(12) : $urandom_range(4);
      queue_byte(CH_STAR);
      add_number(n_el);
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      repeat (n_el) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        queue_byte(CH_DOLLAR);
        add_number(len);
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        // payload leans toward framing characters
        repeat (len) begin
          case ($urandom_range(11))
            0:       queue_byte(CH_CR);
            1:       queue_byte(CH_LF);
            2:       queue_byte(CH_STAR);
            3:       queue_byte(CH_DOLLAR);
            4:       queue_byte(CH_NUL);
            default: queue_byte(8'($urandom));
          endcase
        end
        queue_byte(CH_CR);
        queue_byte(CH_LF);
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
        req_q.delete();
        repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
      end else if (roll < 15) begin
        cut = $urandom_range(1, req_q.size() - 1);
        while (req_q.size() > cut) void'(req_q.pop_back());
      end else if (roll < 22) begin
        req_q[$urandom_range(req_q.size() - 1)] = 8'($urandom);
      end else if ($urandom_range(4) == 0) begin
        queue_byte(CH_NUL);
        if ($urandom_range(3) == 0) queue_byte(CH_NUL);
      end
      foreach (req_q[k]) send_byte(req_q[k]);
      // Pause once per phase until the block has drained
      if (!paused && bytes_sent >= half_way) begin
        paused = 1'b1;
        settle();
      end
    end
  endtask

  initial begin
    int drain;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_MAX_ELEMENTS;
    cfg_ch.data   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Framing at reset limits: zero count, trailing NUL, stray byte, resync,
    // non-digits, consumed star, payload extremes, empty length, last element
    send_text("*0\015\n");
    send_byte(CH_NUL);
    send_byte(CH_NUL);
    send_text("x*1**/");
    send_text("*2\015\n$1\015\n");
    send_byte(8'hFF);
    send_text("\015\n$\015\n\015\n*1\015\n$2\015\n");
    send_byte(CH_NUL);
    send_text("*\015\n7");
    settle();

    // Zero limits: only empty requests pass
    write_limits(16'd0, 32'd0);
    send_text("*0\015\n*1*00\015\n");
    settle();

    // Top limits: overflow at the last digit
    write_limits(16'hFFFF, 32'hFFFF_FFFF);
    send_text("*65536*1\015\n$4294967296*2\015\n$42949672950");
    settle();

    write_limits(16'd1, 32'd0);
    send_text("*1\015\n$0\015\n\015\n*2*1\015\n$1");
    settle();

    // Random phases, each with its own limits and idling
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       write_limits(16'hFFFF, 32'hFFFF_FFFF);
        1:       write_limits(16'd3, 32'd6);
        2:       write_limits(16'd1, 32'd0);
        3:       write_limits(16'($urandom_range(1, 16)), 32'($urandom_range(12)));
        4:       write_limits(16'd0, $urandom);
        5:       write_limits(16'($urandom), $urandom);
        6:       write_limits(MAX_ELEMENTS_RST, MAX_LENGTH_RST);
        default: write_limits(16'd8, 32'd12);
      endcase
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      run_phase(RANDOM_BYTES / PHASES);
    end

    // Drain with a bound, then give the verdict
    in_ch.valid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk_i);
      drain++;
    end while (chk_pending != 0 && drain < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* resp_request_parser.f */
src/rrp_pkg.sv
src/rrp_intf.sv
src/rrp_step.sv
src/resp_request_parser.sv
tb/sv/rrp_checker.sv
tb/sv/testbench.sv
